// ----- hdl/xor_check_byte_stuff_framer_core_assert.svh -----
// assertion macros for the byte stuffing framer
`ifndef XOR_CHECK_BYTE_STUFF_FRAMER_CORE_ASSERT_SVH
`define XOR_CHECK_BYTE_STUFF_FRAMER_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define XCBSF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("framer assertion failed");

// condition implies consequence in the next cycle
`define XCBSF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("framer assertion failed");

`endif

// ----- hdl/xcbsf_pkg.sv -----
// shared types and constants for the byte stuffing framer
`timescale 1ns / 1ps

package xcbsf_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_HEADER    = 3'd0,
    CFG_TAIL      = 3'd1,
    CFG_ESC5E_1ST = 3'd2,
    CFG_ESC5E_2ND = 3'd3,
    CFG_ESC7E_1ST = 3'd4,
    CFG_ESC7E_2ND = 3'd5
  } cfg_idx_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned BYTE_W    = 8;

  // byte values that get escaped
  localparam logic [BYTE_W-1:0] ESC_VAL_5E = 8'h5e;
  localparam logic [BYTE_W-1:0] ESC_VAL_7E = 8'h7e;

  // register reset values
  localparam logic [BYTE_W-1:0] RST_HEADER    = 8'h7e;
  localparam logic [BYTE_W-1:0] RST_TAIL      = 8'h7e;
  localparam logic [BYTE_W-1:0] RST_ESC5E_1ST = 8'h5e;
  localparam logic [BYTE_W-1:0] RST_ESC5E_2ND = 8'h5d;
  localparam logic [BYTE_W-1:0] RST_ESC7E_1ST = 8'h5e;
  localparam logic [BYTE_W-1:0] RST_ESC7E_2ND = 8'h7d;

  // most output beats one input beat can cause, and index width
  localparam int unsigned MAX_OUT = 6;
  localparam int unsigned POS_W   = 3;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef byte_t [MAX_OUT-1:0] out_list_t;

endpackage

// ----- hdl/xcbsf_if.sv -----
// stream interfaces for the framer input and output channels
`timescale 1ns / 1ps

interface xcbsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface xcbsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, output out_byte, output run_last, output frame_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input frame_end,
                output ready);
endinterface

// ----- hdl/xor_check_byte_stuff_framer_core.sv -----
// byte stuffing framer with header, xor check byte and tail
// Usage:
//   in_ch takes one payload byte per beat, last_byte marks the frame's final byte.
//   out_ch gives the framed stream one byte per beat: header before the first
//   payload byte, each payload byte escaped (0x5e and 0x7e become configured
//   pairs), and after the final byte the escaped xor check byte and the tail.
//   run_last flags the final output beat caused by an input beat, frame_end the tail.
//   cfg_we/cfg_index/cfg_wdata write the six byte registers; write only when idle.
// Path: an accepted beat's results are expanded into a list register, then
//   sent through an output register.
// Throughput: one output byte per cycle while out_ch.ready is high; a beat that makes
//   N output bytes (1 to 6) holds the port for N bytes, so plain bytes flow one per
//   cycle and escaped bytes go out as pairs. The single output port sets the rate.
// Reset: rst_n is synchronous, active low; the frame state, check byte and both
//   registers empty out, and the configuration returns to its default values.
// Stall: while out_ch.ready is low the output register holds its beat, the list
//   register fills and in_ch.ready drops until the list drains.
`timescale 1ns / 1ps

`include "xor_check_byte_stuff_framer_core_assert.svh"

module xor_check_byte_stuff_framer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  xcbsf_in_if.sink                        in_ch,
  xcbsf_out_if.source                     out_ch,
  input  logic                            cfg_we,
  input  logic [xcbsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [xcbsf_pkg::BYTE_W-1:0]    cfg_wdata
);
  import xcbsf_pkg::*;

  // configuration registers
  byte_t header_r, tail_r, esc5e_a_r, esc5e_b_r, esc7e_a_r, esc7e_b_r;

  // frame state
  byte_t check_r;
  logic  in_frame_r;

  // list register holding one beat's expanded output
  out_list_t        list_r;
  logic             list_vld_r;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] cnt_m1_r;
  logic             list_end_r;

  // output register
  byte_t out_byte_r;
  logic  out_vld_r, out_run_last_r, out_frame_end_r;

  // comb
  out_list_t        list_nxt;
  logic [POS_W-1:0] n_nxt;
  byte_t            chk_nxt;
  logic             in_acc, out_load, list_done, item_last;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_load  = list_vld_r && (!out_vld_r || out_ch.ready);
  assign list_done = out_load && (pos_r == cnt_m1_r);
  assign item_last = (pos_r == cnt_m1_r);

  assign in_ch.ready      = !list_vld_r || list_done;
  assign out_ch.valid     = out_vld_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.run_last  = out_run_last_r;
  assign out_ch.frame_end = out_frame_end_r;

  // configuration writes, out of range indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= RST_HEADER;
      tail_r    <= RST_TAIL;
      esc5e_a_r <= RST_ESC5E_1ST;
      esc5e_b_r <= RST_ESC5E_2ND;
      esc7e_a_r <= RST_ESC7E_1ST;
      esc7e_b_r <= RST_ESC7E_2ND;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HEADER:    header_r  <= cfg_wdata;
        CFG_TAIL:      tail_r    <= cfg_wdata;
        CFG_ESC5E_1ST: esc5e_a_r <= cfg_wdata;
        CFG_ESC5E_2ND: esc5e_b_r <= cfg_wdata;
        CFG_ESC7E_1ST: esc7e_a_r <= cfg_wdata;
        CFG_ESC7E_2ND: esc7e_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // expand one input beat into its output byte list
  always_comb begin
    list_nxt = '0;
    n_nxt    = '0;
    chk_nxt  = check_r ^ in_ch.data_byte;
    if (!in_frame_r) begin
      list_nxt[n_nxt] = header_r;
      n_nxt = n_nxt + 3'd1;
    end
    // escaped payload byte
    if (in_ch.data_byte == ESC_VAL_5E) begin
      list_nxt[n_nxt]        = esc5e_a_r;
      list_nxt[n_nxt + 3'd1] = esc5e_b_r;
      n_nxt = n_nxt + 3'd2;
    end else if (in_ch.data_byte == ESC_VAL_7E) begin
      list_nxt[n_nxt]        = esc7e_a_r;
      list_nxt[n_nxt + 3'd1] = esc7e_b_r;
      n_nxt = n_nxt + 3'd2;
    end else begin
      list_nxt[n_nxt] = in_ch.data_byte;
      n_nxt = n_nxt + 3'd1;
    end
    // escaped check byte and tail on the final byte
    if (in_ch.last_byte) begin
      if (chk_nxt == ESC_VAL_5E) begin
        list_nxt[n_nxt]        = esc5e_a_r;
        list_nxt[n_nxt + 3'd1] = esc5e_b_r;
        n_nxt = n_nxt + 3'd2;
      end else if (chk_nxt == ESC_VAL_7E) begin
        list_nxt[n_nxt]        = esc7e_a_r;
        list_nxt[n_nxt + 3'd1] = esc7e_b_r;
        n_nxt = n_nxt + 3'd2;
      end else begin
        list_nxt[n_nxt] = chk_nxt;
        n_nxt = n_nxt + 3'd1;
      end
      list_nxt[n_nxt] = tail_r;
      n_nxt = n_nxt + 3'd1;
    end
  end

  // frame state update on accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_r    <= '0;
      in_frame_r <= 1'b0;
    end else if (in_acc) begin
      check_r    <= in_ch.last_byte ? '0 : chk_nxt;
      in_frame_r <= !in_ch.last_byte;
    end
  end

  // list register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_vld_r <= 1'b0;
      pos_r      <= '0;
    end else if (in_acc) begin
      list_vld_r <= 1'b1;
      pos_r      <= '0;
    end else if (list_done) begin
      list_vld_r <= 1'b0;
      pos_r      <= '0;
    end else if (out_load) begin
      pos_r <= pos_r + 3'd1;
    end
  end

  // list payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      list_r     <= list_nxt;
      cnt_m1_r   <= n_nxt - 3'd1;
      list_end_r <= in_ch.last_byte;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r      <= list_r[pos_r];
      out_run_last_r  <= item_last;
      out_frame_end_r <= item_last && list_end_r;
    end
  end

  // checks
  `XCBSF_ASSERT_IMP(a_tail_ends_beat, out_ch.valid && out_ch.frame_end, out_ch.run_last)
  `XCBSF_ASSERT_IMP(a_pos_in_range, list_vld_r, pos_r <= cnt_m1_r)
  `XCBSF_ASSERT_NXT(a_list_held, list_vld_r && !out_load, list_vld_r && $stable(pos_r))
  `XCBSF_ASSERT_NXT(a_frame_closed, in_acc && in_ch.last_byte, !in_frame_r && check_r == '0)

endmodule
